@@ rtl/core/greedy_point_pair_merger_macros.svh @@
// ----------------------------------------------------------------------------
// Greedy point pair merger assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GREEDY_POINT_PAIR_MERGER_MACROS_SVH
`define GREEDY_POINT_PAIR_MERGER_MACROS_SVH

// same-cycle implication
`define GPPM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gppm assertion failed");

// next-cycle implication
`define GPPM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gppm assertion failed");

`endif

@@ rtl/core/gppm_pkg.sv @@
// ----------------------------------------------------------------------------
// gppm_pkg
// Shared constants, types and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package gppm_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W        = 16;
    localparam int DIFF_W         = 17;
    localparam int ANG_W          = 17;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_TOL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ANG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_TOL    = 3'd3;

    typedef struct packed {
        logic                     go;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } cordic_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ANG_W-1:0] angle;
    } cordic_rsp_t;

    // atan(2^-i) in degrees * 2^16
    function automatic logic [22:0] atan_deg16(input logic [3:0] i);
        logic [22:0] v;
        case (i)
            4'd0:    v = 23'd2949120;
            4'd1:    v = 23'd1740967;
            4'd2:    v = 23'd919879;
            4'd3:    v = 23'd466945;
            4'd4:    v = 23'd234379;
            4'd5:    v = 23'd117304;
            4'd6:    v = 23'd58666;
            4'd7:    v = 23'd29335;
            4'd8:    v = 23'd14668;
            4'd9:    v = 23'd7334;
            4'd10:   v = 23'd3667;
            4'd11:   v = 23'd1833;
            4'd12:   v = 23'd917;
            4'd13:   v = 23'd458;
            4'd14:   v = 23'd229;
            default: v = 23'd115;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/greedy_point_pair_merger.sv @@
// Loading: one point per cycle while busy is low; a point past MAX_POINTS is dropped.
// Pairing starts after the point marked last: setup squares the separation bounds, then each
// alive first point is loaded and each alive candidate is read and squared; the CORDIC unit is
// awaited when the distance test passes, dead entries are skipped; one shared 17x17 multiplier.
// Results are one-cycle strobes on result_valid; the receiver cannot stall.
// rst_n clears state, flags, alive flags and point count; datapath regs and the point RAM are not.
// ----------------------------------------------------------------------------
// greedy_point_pair_merger
// Stores a point list and greedily merges qualifying point pairs; each midpoint is output as x1+x2, y1+y2.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_point_pair_merger
    import gppm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_W-1:0]    point_x,
    input  wire logic [COORD_W-1:0]    point_y,
    input  wire logic                  point_last,
    output logic                       result_valid,
    output logic [COORD_W:0]           mid_x,
    output logic [COORD_W:0]           mid_y,
    output logic                       pair_found,
    output logic                       result_last
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 2 * DIFF_W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_SQ0  = 12'b000000000010,
        S_SQ1  = 12'b000000000100,
        S_FIND = 12'b000000001000,
        S_LDF  = 12'b000000010000,
        S_SCAN = 12'b000000100000,
        S_RDJ  = 12'b000001000000,
        S_MX   = 12'b000010000000,
        S_MY   = 12'b000100000000,
        S_DIST = 12'b001000000000,
        S_WAIT = 12'b010000000000,
        S_DONE = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] sep_reg, tol_reg, tang_reg;
    logic [14:0] atol_reg;

    logic [MAX_POINTS-1:0] alive_reg, alive_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         f_reg, f_next;
    logic [CW-1:0]         j_reg, j_next;

    logic [PW-1:0] hi2_reg, hi2_next;
    logic [PW-1:0] lo2_reg, lo2_next;
    logic [PW-1:0] d2_reg, d2_next;
    logic [PW-1:0] bd2_reg, bd2_next;

    logic [COORD_W-1:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [COORD_W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [DIFF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic          best_reg, best_next;
    logic [IW-1:0] bidx_reg, bidx_next;

    logic            pend_reg, pend_next;
    logic [COORD_W:0] pmx_reg, pmx_next, pmy_reg, pmy_next;

    logic             ov_reg, ov_next, ol_reg, ol_next, of_reg, of_next;
    logic [COORD_W:0] omx_reg, omx_next, omy_reg, omy_next;

    logic                  ram_we;
    logic [IW-1:0]         ram_raddr;
    logic [2*COORD_W-1:0]  ram_rdata;

    logic [DIFF_W-1:0] mul_a, mul_b;
    logic [PW-1:0]     prod;

    logic signed [DIFF_W-1:0] lo_s;
    logic [DIFF_W-1:0]        hi_u;
    logic                     dist_ok, ang_ok;
    logic signed [18:0]       dm, dp, adm, adp, atol_s;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    assign busy = (state_reg != S_IDLE);
    assign ram_we = (state_reg == S_IDLE) && start && (count_reg < CW'(MAX_POINTS));

    gppm_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IW-1:0]),
        .wdata ({point_x, point_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gppm_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    assign prod = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg  <= '0;
            tol_reg  <= '0;
            tang_reg <= '0;
            atol_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_SEP: sep_reg  <= cfg_data;
                CFG_SEP_TOL:    tol_reg  <= cfg_data;
                CFG_TARGET_ANG: tang_reg <= cfg_data;
                CFG_ANG_TOL:    atol_reg <= cfg_data[14:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        lo_s = $signed({1'b0, sep_reg}) - $signed({1'b0, tol_reg});
        hi_u = {1'b0, sep_reg} + {1'b0, tol_reg};

        dist_ok = (d2_reg < hi2_reg) && (lo_s[DIFF_W-1] || (d2_reg > lo2_reg));

        dm     = 19'(crsp.angle) - 19'($signed(tang_reg));
        dp     = 19'(crsp.angle) + 19'($signed(tang_reg));
        adm    = dm[18] ? -dm : dm;
        adp    = dp[18] ? -dp : dp;
        atol_s = $signed({4'b0, atol_reg});
        ang_ok = (adm < atol_s) || (adp < atol_s);

        case (state_reg)
            S_SQ0:
            begin
                mul_a = hi_u;
                mul_b = hi_u;
            end
            S_SQ1:
            begin
                mul_a = lo_s[DIFF_W-1] ? DIFF_W'(-lo_s) : DIFF_W'(lo_s);
                mul_b = mul_a;
            end
            S_MX:
            begin
                mul_a = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
                mul_b = mul_a;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        alive_next = alive_reg;
        count_next = count_reg;
        f_next     = f_reg;
        j_next     = j_reg;
        hi2_next   = hi2_reg;
        lo2_next   = lo2_reg;
        d2_next    = d2_reg;
        bd2_next   = bd2_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        pend_next  = pend_reg;
        pmx_next   = pmx_reg;
        pmy_next   = pmy_reg;
        ov_next    = 1'b0;
        ol_next    = ol_reg;
        of_next    = of_reg;
        omx_next   = omx_reg;
        omy_next   = omy_reg;
        ram_raddr  = f_reg[IW-1:0];
        creq.go    = 1'b0;
        creq.dx    = dx_reg;
        creq.dy    = dy_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (ram_we)
                    begin
                        alive_next[count_reg[IW-1:0]] = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (point_last)
                    begin
                        pend_next  = 1'b0;
                        f_next     = '0;
                        state_next = S_SQ0;
                    end
                end
            end
            S_SQ0:
            begin
                hi2_next   = prod;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                lo2_next   = prod;
                state_next = S_FIND;
            end
            S_FIND:
            begin
                if (f_reg >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else if (alive_reg[f_reg[IW-1:0]])
                begin
                    ram_raddr  = f_reg[IW-1:0];
                    state_next = S_LDF;
                end
                else
                begin
                    f_next = f_reg + CW'(1);
                end
            end
            S_LDF:
            begin
                fx_next    = ram_rdata[2*COORD_W-1:COORD_W];
                fy_next    = ram_rdata[COORD_W-1:0];
                j_next     = f_reg + CW'(1);
                best_next  = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (j_reg >= count_reg)
                begin
                    f_next     = f_reg + CW'(1);
                    state_next = S_FIND;
                    if (best_reg)
                    begin
                        alive_next[bidx_reg] = 1'b0;
                        pend_next = 1'b1;
                        pmx_next  = {1'b0, fx_reg} + {1'b0, bx_reg};
                        pmy_next  = {1'b0, fy_reg} + {1'b0, by_reg};
                        if (pend_reg)
                        begin
                            ov_next  = 1'b1;
                            ol_next  = 1'b0;
                            of_next  = 1'b1;
                            omx_next = pmx_reg;
                            omy_next = pmy_reg;
                        end
                    end
                end
                else if (alive_reg[j_reg[IW-1:0]])
                begin
                    ram_raddr  = j_reg[IW-1:0];
                    state_next = S_RDJ;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            S_RDJ:
            begin
                px_next    = ram_rdata[2*COORD_W-1:COORD_W];
                py_next    = ram_rdata[COORD_W-1:0];
                dx_next    = $signed({1'b0, fx_reg}) -
                             $signed({1'b0, ram_rdata[2*COORD_W-1:COORD_W]});
                dy_next    = $signed({1'b0, fy_reg}) -
                             $signed({1'b0, ram_rdata[COORD_W-1:0]});
                state_next = S_MX;
            end
            S_MX:
            begin
                d2_next    = prod;
                state_next = S_MY;
            end
            S_MY:
            begin
                d2_next    = d2_reg + prod;
                state_next = S_DIST;
            end
            S_DIST:
            begin
                if (dist_ok)
                begin
                    creq.go    = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_WAIT:
            begin
                if (crsp.done)
                begin
                    if (ang_ok && (!best_reg || d2_reg < bd2_reg))
                    begin
                        best_next = 1'b1;
                        bidx_next = j_reg[IW-1:0];
                        bd2_next  = d2_reg;
                        bx_next   = px_reg;
                        by_next   = py_reg;
                    end
                    j_next     = j_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_DONE:
            begin
                ov_next    = 1'b1;
                ol_next    = 1'b1;
                of_next    = pend_reg;
                omx_next   = pend_reg ? pmx_reg : '0;
                omy_next   = pend_reg ? pmy_reg : '0;
                pend_next  = 1'b0;
                alive_next = '0;
                count_next = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            alive_reg <= '0;
            count_reg <= '0;
            f_reg     <= '0;
            j_reg     <= '0;
            best_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            ol_reg    <= 1'b0;
            of_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            alive_reg <= alive_next;
            count_reg <= count_next;
            f_reg     <= f_next;
            j_reg     <= j_next;
            best_reg  <= best_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            ol_reg    <= ol_next;
            of_reg    <= of_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi2_reg  <= hi2_next;
        lo2_reg  <= lo2_next;
        d2_reg   <= d2_next;
        bd2_reg  <= bd2_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        bidx_reg <= bidx_next;
        pmx_reg  <= pmx_next;
        pmy_reg  <= pmy_next;
        omx_reg  <= omx_next;
        omy_reg  <= omy_next;
    end

    assign result_valid = ov_reg;
    assign result_last  = ol_reg;
    assign pair_found   = of_reg;
    assign mid_x        = omx_reg;
    assign mid_y        = omy_reg;

endmodule

`default_nettype wire

@@ rtl/core/gppm_ram.sv @@
// ----------------------------------------------------------------------------
// gppm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gppm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/gppm_cordic.sv @@
// ----------------------------------------------------------------------------
// gppm_cordic
// Iterative CORDIC vectoring unit: atan2(dy, dx) in signed Q9.7 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module gppm_cordic
    import gppm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cordic_req_t req,
    output cordic_rsp_t      rsp
);

    localparam int XW = 36;
    localparam int ZW = 26;

    logic                    run_reg, run_next;
    logic [4:0]              i_reg, i_next;
    logic signed [XW-1:0]    x_reg, x_next;
    logic signed [XW-1:0]    y_reg, y_next;
    logic signed [ZW-1:0]    z_reg, z_next;
    logic                    done_reg, done_next;
    logic signed [ANG_W-1:0] ang_reg, ang_next;

    logic signed [DIFF_W-1:0] adx, ndy;
    logic signed [XW-1:0]     xs, ys;
    logic signed [ZW-1:0]     tz, zsum;

    always_comb
    begin
        adx  = req.dx[DIFF_W-1] ? -req.dx : req.dx;
        ndy  = req.dx[DIFF_W-1] ? -req.dy : req.dy;
        xs   = x_reg >>> i_reg[3:0];
        ys   = y_reg >>> i_reg[3:0];
        tz   = ZW'($signed({1'b0, atan_deg16(i_reg[3:0])}));
        zsum = z_reg + ZW'(256);

        run_next  = run_reg;
        i_next    = i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done_next = 1'b0;
        ang_next  = ang_reg;

        if (req.go)
        begin
            if (req.dx == '0)
            begin
                done_next = 1'b1;
                if (req.dy[DIFF_W-1])
                begin
                    ang_next = -ANG_W'(11520);
                end
                else if (req.dy != '0)
                begin
                    ang_next = ANG_W'(11520);
                end
                else
                begin
                    ang_next = '0;
                end
            end
            else
            begin
                run_next = 1'b1;
                i_next   = '0;
                x_next   = XW'(adx) <<< 14;
                y_next   = XW'(ndy) <<< 14;
                if (!req.dx[DIFF_W-1])
                begin
                    z_next = '0;
                end
                else if (req.dy[DIFF_W-1])
                begin
                    z_next = -ZW'(11796480);
                end
                else
                begin
                    z_next = ZW'(11796480);
                end
            end
        end
        else if (run_reg)
        begin
            if (y_reg == '0 || i_reg == 5'd16)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                ang_next  = zsum[ZW-1:9];
            end
            else
            begin
                i_next = i_reg + 5'd1;
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + tz;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - tz;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        ang_reg <= ang_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = ang_reg;

endmodule

`default_nettype wire

@@ rtl/core/gppm_checker.sv @@
// ----------------------------------------------------------------------------
// gppm_checker
// Port-level checks on request and result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_point_pair_merger_macros.svh"

module gppm_checker
    import gppm_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             point_last,
    input wire logic             result_valid,
    input wire logic [COORD_W:0] mid_x,
    input wire logic [COORD_W:0] mid_y,
    input wire logic             pair_found,
    input wire logic             result_last
);

    `GPPM_ASSERT_NXT(a_last_req_busy, start && !busy && point_last, busy)
    `GPPM_ASSERT_NXT(a_plain_req_quiet, start && !busy && !point_last, !result_valid)
    `GPPM_ASSERT_IMP(a_final_idle, result_valid && result_last, !busy)
    `GPPM_ASSERT_IMP(a_mid_busy, result_valid && !result_last, busy && pair_found)
    `GPPM_ASSERT_IMP(a_empty_item, result_valid && !pair_found,
                     result_last && mid_x == '0 && mid_y == '0)

endmodule

bind greedy_point_pair_merger gppm_checker u_gppm_checker (.*);

`default_nettype wire

@@ verif/greedy_point_pair_merger_checker.sv @@
// ----------------------------------------------------------------------------
// Greedy point pair merger checker
// Watches the config, request and result ports, predicts the midpoints of
// each run from its own copy of the point list and compares every result.
// ----------------------------------------------------------------------------
module greedy_point_pair_merger_checker
    import gppm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    input  logic                  busy,
    input  logic [COORD_W-1:0]    point_x,
    input  logic [COORD_W-1:0]    point_y,
    input  logic                  point_last,
    input  logic                  result_valid,
    input  logic [COORD_W:0]      mid_x,
    input  logic [COORD_W:0]      mid_y,
    input  logic                  pair_found,
    input  logic                  result_last,
    output int                    pending,
    output int                    failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int QDEPTH = 64;
    localparam longint ATAN_DEG16 [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic [COORD_W:0] mx;
        logic [COORD_W:0] my;
        logic             found;
        logic             fin;
    } midpoint_t;

    midpoint_t         expect_mem [QDEPTH];
    int                wr_cnt;
    int                rd_cnt;
    logic [15:0]       sep_reg, sep_tol_reg, ang_reg;
    logic [14:0]       ang_tol_reg;
    logic [15:0]       list_x [DEPTH];
    logic [15:0]       list_y [DEPTH];
    bit                alive [DEPTH];
    int                list_len;

    function automatic longint heading_q7(longint dx, longint dy);
        longint base, x, y, z, nx;
        base = 0;
        z = 0;
        if (dx == 0)
            return (dy > 0) ? 90 * 128 : (dy < 0) ? -90 * 128 : 0;
        if (dx < 0)
        begin
            base = (dy >= 0) ? 180 * 65536 : -180 * 65536;
            dx = -dx;
            dy = -dy;
        end
        x = dx * 16384;
        y = dy * 16384;
        for (int i = 0; i < 16; i++)
        begin
            if (y == 0)
                break;
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_DEG16[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_DEG16[i];
            end
            x = nx;
        end
        return (base + z + 256) >>> 9;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic add_expected(input midpoint_t m);
        expect_mem[wr_cnt % QDEPTH] = m;
        wr_cnt++;
    endtask

    task automatic pair_points();
        longint hi, lo, ang, atol, fx, fy, dx, dy, d2, a, best_d2;
        int best, found_cnt;
        midpoint_t m;
        hi = longint'(sep_reg) + longint'(sep_tol_reg);
        lo = longint'(sep_reg) - longint'(sep_tol_reg);
        ang = longint'($signed(ang_reg));
        atol = longint'(ang_tol_reg);
        found_cnt = 0;
        for (int f = 0; f < list_len; f++)
        begin
            if (!alive[f])
                continue;
            alive[f] = 0;
            fx = list_x[f];
            fy = list_y[f];
            best = -1;
            best_d2 = 0;
            for (int j = f + 1; j < list_len; j++)
            begin
                if (!alive[j])
                    continue;
                dx = fx - longint'(list_x[j]);
                dy = fy - longint'(list_y[j]);
                d2 = dx * dx + dy * dy;
                if (!(d2 < hi * hi && (lo < 0 || d2 > lo * lo)))
                    continue;
                a = heading_q7(dx, dy);
                if (!(mag(a - ang) < atol || mag(a + ang) < atol))
                    continue;
                if (best < 0 || d2 < best_d2)
                begin
                    best = j;
                    best_d2 = d2;
                end
            end
            if (best >= 0)
            begin
                alive[best] = 0;
                m.mx = 17'(fx + longint'(list_x[best]));
                m.my = 17'(fy + longint'(list_y[best]));
                m.found = 1'b1;
                m.fin = 1'b0;
                add_expected(m);
                found_cnt++;
            end
        end
        if (found_cnt == 0)
        begin
            m.mx = '0;
            m.my = '0;
            m.found = 1'b0;
            m.fin = 1'b1;
            add_expected(m);
        end
        else
            expect_mem[(wr_cnt - 1) % QDEPTH].fin = 1'b1;
        for (int k = 0; k < DEPTH; k++)
            alive[k] = 0;
        list_len = 0;
    endtask

    task automatic compare_result();
        midpoint_t m;
        if (wr_cnt == rd_cnt)
        begin
            $error("unexpected result mid_x=%0d mid_y=%0d", mid_x, mid_y);
            failures++;
            return;
        end
        m = expect_mem[rd_cnt % QDEPTH];
        rd_cnt++;
        if (mid_x !== m.mx)
        begin
            $error("mid_x expected %0d actual %0d", m.mx, mid_x);
            failures++;
        end
        if (mid_y !== m.my)
        begin
            $error("mid_y expected %0d actual %0d", m.my, mid_y);
            failures++;
        end
        if (pair_found !== m.found)
        begin
            $error("pair_found expected %0d actual %0d", m.found, pair_found);
            failures++;
        end
        if (result_last !== m.fin)
        begin
            $error("result_last expected %0d actual %0d", m.fin, result_last);
            failures++;
        end
    endtask

    initial
    begin
        failures = 0;
        list_len = 0;
        wr_cnt = 0;
        rd_cnt = 0;
        for (int k = 0; k < DEPTH; k++)
            alive[k] = 0;
    end

    assign pending = wr_cnt - rd_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg = '0;
            sep_tol_reg = '0;
            ang_reg = '0;
            ang_tol_reg = '0;
            list_len = 0;
            for (int k = 0; k < DEPTH; k++)
                alive[k] = 0;
        end
        else
        begin
            if (result_valid)
                compare_result();
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET_SEP: sep_reg = cfg_data;
                    CFG_SEP_TOL:    sep_tol_reg = cfg_data;
                    CFG_TARGET_ANG: ang_reg = cfg_data;
                    CFG_ANG_TOL:    ang_tol_reg = cfg_data[14:0];
                    default:        ;
                endcase
            end
            if (start && !busy)
            begin
                if (list_len < DEPTH)
                begin
                    list_x[list_len] = point_x;
                    list_y[list_len] = point_y;
                    alive[list_len] = 1;
                    list_len++;
                end
                if (point_last)
                    pair_points();
            end
        end
    end

endmodule

@@ verif/greedy_point_pair_merger_test.sv @@
// ----------------------------------------------------------------------------
// Greedy point pair merger testbench
// Loads point lists in bursts, directed extremes first and then random and
// clustered lists under several tolerance settings; the checker compares
// every emitted midpoint.
// ----------------------------------------------------------------------------
module greedy_point_pair_merger_test
    import gppm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
    localparam int TARGET_REQUESTS = 380;
    localparam int IDLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  start;
    logic                  busy;
    logic [COORD_W-1:0]    point_x;
    logic [COORD_W-1:0]    point_y;
    logic                  point_last;
    logic                  result_valid;
    logic [COORD_W:0]      mid_x;
    logic [COORD_W:0]      mid_y;
    logic                  pair_found;
    logic                  result_last;
    int                    pending;
    int                    failures;
    int                    requests_sent;
    int                    burst_left;
    int                    idle_cycles;

    greedy_point_pair_merger uut (.*);
    greedy_point_pair_merger_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [15:0] sep, tol, ang, atol);
        write_reg(CFG_TARGET_SEP, sep);
        write_reg(CFG_SEP_TOL, tol);
        write_reg(CFG_TARGET_ANG, ang);
        write_reg(CFG_ANG_TOL, atol);
    endtask

    task automatic send_point(input logic [15:0] x, y, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = int'($urandom_range(1, 8));
            start <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 10));
        end
        while (busy)
            @(negedge clk);
        start <= 1'b1;
        point_x <= x;
        point_y <= y;
        point_last <= fin;
        @(negedge clk);
        burst_left--;
        requests_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // clustered lists pair often; wide lists exercise every coordinate bit
    task automatic send_list(input int n, input bit wide);
        logic [15:0] bx, by, x, y;
        bx = 16'($urandom_range(0, 65535 - 1024));
        by = 16'($urandom_range(0, 65535 - 1024));
        for (int i = 0; i < n; i++)
        begin
            if (wide)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else
            begin
                x = bx + 16'($urandom_range(0, 1023));
                y = by + 16'($urandom_range(0, 1023));
            end
            send_point(x, y, i == n - 1);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        point_x = '0;
        point_y = '0;
        point_last = 1'b0;
        requests_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: nothing qualifies; single point gives the empty item
        send_point(16'd0, 16'd0, 1'b1);
        wait_drained();
        send_point(16'hFFFF, 16'hFFFF, 1'b0);
        send_point(16'd0, 16'd0, 1'b1);
        wait_drained();

        set_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd23040);
        write_reg(CFG_UNUSED, 16'h1234);
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'hFFFF, 16'hFFFF, 1'b0);
        send_point(16'hFFFF, 16'd0, 1'b0);
        send_point(16'd0, 16'hFFFF, 1'b0);
        send_point(16'd100, 16'd100, 1'b0);
        send_point(16'd100, 16'd100, 1'b0);
        send_point(16'd100, 16'd164, 1'b0);
        send_point(16'd36, 16'd100, 1'b1);
        wait_drained();

        set_regs(16'd160, 16'd0, 16'h8000 | 16'(-23040), 16'd0);
        send_list(3, 1'b0);
        set_regs(16'd320, 16'd200, 16'(-23040), 16'h7FFF);
        send_list(4, 1'b0);

        // overfull list: the points past the store depth are dropped
        set_regs(16'd300, 16'd300, 16'd5760, 16'd11520);
        send_list(70, 1'b0);

        while (requests_sent < TARGET_REQUESTS)
        begin
            if ($urandom_range(0, 3) == 0)
                set_regs(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 600)),
                         16'(int'($urandom_range(0, 46080)) - 23040),
                         16'($urandom_range(0, 23040)));
            if ($urandom_range(0, 20) == 0)
                send_list(int'($urandom_range(60, 66)), 1'b0);
            else
                send_list(int'($urandom_range(1, 12)), $urandom_range(0, 4) == 0);
        end

        wait_drained();
        repeat (50) @(negedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/gppm_pkg.sv
rtl/core/gppm_ram.sv
rtl/core/gppm_cordic.sv
rtl/core/greedy_point_pair_merger.sv
rtl/core/gppm_checker.sv
verif/greedy_point_pair_merger_checker.sv
verif/greedy_point_pair_merger_test.sv
